[hw/rtl/aoc_pkg.sv]
// Shared types, constants and the arctangent table of the angle offset calibrator.
package aoc_pkg;

	localparam int COUNT_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int ANG_W  = 20;
	localparam int TIME_W = 32;
	localparam int SUM_W  = 32;
	localparam int OFS_W  = 16;
	localparam int SPAN_W = 20;
	localparam int XY_W   = 36;
	localparam int Z_W    = 34;
	localparam int Q15_W  = 16;

	localparam int TAB_LEN   = 24;
	localparam int TAB_IDX_W = 5;

	localparam logic signed [XY_W-1:0] GAIN_Q30 = 36'sd652032874;

	localparam logic [TIME_W-1:0] CALIB_TIME_RST = 32'd2000000;
	localparam logic [SPAN_W-1:0] MAX_SPAN_RST   = 20'd910;

	localparam logic signed [ANG_W-1:0] ANG_MAX = 20'sh7FFFF;
	localparam logic signed [ANG_W-1:0] ANG_MIN = 20'sh80000;

	typedef enum logic {
		REG_CALIB_TIME,
		REG_MAX_SPAN
	} aoc_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_ACCUM,
		ST_CHECK,
		ST_VEC,
		ST_VEC_DONE,
		ST_OUT
	} aoc_state_t;

	typedef struct packed {
		logic                   start;
		logic                   vec;
		logic signed [XY_W-1:0] x0;
		logic signed [XY_W-1:0] y0;
		logic signed [Z_W-1:0]  z0;
	} aoc_cordic_cmd_t;

	typedef struct packed {
		logic                   done;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} aoc_cordic_res_t;

	function automatic logic signed [Z_W-1:0] atan_val(input logic [TAB_IDX_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			5'd0:    v = 34'sd536870912;
			5'd1:    v = 34'sd316933406;
			5'd2:    v = 34'sd167458907;
			5'd3:    v = 34'sd85004756;
			5'd4:    v = 34'sd42667331;
			5'd5:    v = 34'sd21354465;
			5'd6:    v = 34'sd10679838;
			5'd7:    v = 34'sd5340245;
			5'd8:    v = 34'sd2670163;
			5'd9:    v = 34'sd1335087;
			5'd10:   v = 34'sd667544;
			5'd11:   v = 34'sd333772;
			5'd12:   v = 34'sd166886;
			5'd13:   v = 34'sd83443;
			5'd14:   v = 34'sd41722;
			5'd15:   v = 34'sd20861;
			5'd16:   v = 34'sd10430;
			5'd17:   v = 34'sd5215;
			5'd18:   v = 34'sd2608;
			5'd19:   v = 34'sd1304;
			5'd20:   v = 34'sd652;
			5'd21:   v = 34'sd326;
			5'd22:   v = 34'sd163;
			5'd23:   v = 34'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/aoc_regs.sv]
// APB configuration registers: calibration window length and span limit.
module aoc_regs
	import aoc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [TIME_W-1:0] calib_time,
	output logic [SPAN_W-1:0] max_span
);

	logic [TIME_W-1:0] calib_time_q;
	logic [SPAN_W-1:0] max_span_q;
	aoc_reg_t          sel;
	logic              wr_en;

	assign sel    = aoc_reg_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_time_q <= CALIB_TIME_RST;
			max_span_q   <= MAX_SPAN_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_CALIB_TIME: calib_time_q <= pwdata;
				REG_MAX_SPAN:   max_span_q   <= pwdata[SPAN_W-1:0];
				default:        calib_time_q <= calib_time_q;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_CALIB_TIME: prdata = calib_time_q;
			REG_MAX_SPAN:   prdata = {{(32-SPAN_W){1'b0}}, max_span_q};
			default:        prdata = '0;
		endcase
	end

	assign calib_time = calib_time_q;
	assign max_span   = max_span_q;

endmodule

[hw/rtl/aoc_cordic.sv]
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module aoc_cordic
	import aoc_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  aoc_cordic_cmd_t cmd,
	output aoc_cordic_res_t res
);

	localparam int CNT_W = $clog2(CORDIC_STEPS);

	logic signed [XY_W-1:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0]  z_q, atan;
	logic                   vec_q, busy_q, done_q, dir, last;
	logic [CNT_W-1:0]       cnt_q;

	assign dir  = vec_q ? y_q[XY_W-1] : !z_q[Z_W-1];
	assign dx   = y_q >>> cnt_q;
	assign dy   = x_q >>> cnt_q;
	assign atan = atan_val(TAB_IDX_W'(cnt_q));
	assign last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			vec_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				vec_q  <= cmd.vec;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= cmd.x0;
			y_q <= cmd.y0;
			z_q <= cmd.z0;
		end else if (busy_q) begin
			if (dir) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan;
			end
		end
	end

	assign res.done = done_q;
	assign res.x    = x_q;
	assign res.y    = y_q;
	assign res.z    = z_q;

endmodule

[hw/rtl/angle_offset_calibrator.sv]
// Angle offset calibrator top level: stream ports, sequencer, sums and flags.
// A start item or a sample outside calibration goes from idle straight to ST_OUT.
// A calibration sample below the count limit first runs the shared CORDIC rotation in ST_ROT.
// A sample closing an in-span window with non-zero sums adds CORDIC vectoring in ST_VEC.
// One item at a time: s_tready is high only while the sequencer is idle.
// Reset clears flags, sums and offset, sets the window to 2000000 us and the span limit to 910.
module angle_offset_calibrator
	import aoc_pkg::*;
#(
	parameter int COUNT_BITS   = COUNT_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // angle[19:0], now_us[51:20], zero[55:52]
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // finished[0], running[1], ready_res[2], rejected[3],
	                              // offset[19:4], span[39:20], corrected_angle[55:40]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	aoc_state_t state_q, state_d;
	aoc_cordic_cmd_t cmd;
	aoc_cordic_res_t res;

	logic [TIME_W-1:0] calib_time;
	logic [SPAN_W-1:0] max_span;

	logic                    running_q, ready_q, rejected_q, fin_q, flip_q;
	logic [TIME_W-1:0]       start_q, now_q, elapsed;
	logic [COUNT_BITS-1:0]   count_q;
	logic signed [SUM_W-1:0] sin_sum_q, cos_sum_q;
	logic signed [ANG_W-1:0] min_q, max_q, ang_q, new_min, new_max, ang_in;
	logic [SPAN_W-1:0]       span_q, span_w;
	logic signed [OFS_W-1:0] offset_q;
	logic [55:0]             m_tdata_q;
	logic                    m_tvalid_q;

	logic        accept, out_free, count_full, fin_w, rej_w, zero_w;
	logic [31:0] phase;
	logic        flip_w;
	logic signed [XY_W-1:0] xf, yf;
	logic signed [Z_W-1:0]  z_round;

	aoc_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.calib_time (calib_time),
		.max_span   (max_span)
	);

	aoc_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
		logic signed [XY_W:0]   t;
		logic signed [XY_W-15:0] r;
		logic signed [Q15_W-1:0] o;
		t = {v[XY_W-1], v} + 37'sd16384;
		r = t[XY_W:15];
		if (r > 22'sd32767)
			o = 16'sd32767;
		else if (r < -22'sd32767)
			o = -16'sd32767;
		else
			o = r[Q15_W-1:0];
		return o;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
			input logic signed [Q15_W-1:0] b);
		logic signed [SUM_W:0]   s;
		logic signed [SUM_W-1:0] o;
		s = {a[SUM_W-1], a} + {{(SUM_W-Q15_W+1){b[Q15_W-1]}}, b};
		if (s > 33'sh0_7FFF_FFFF)
			o = 32'sh7FFF_FFFF;
		else if (s < -33'sh0_8000_0000)
			o = 32'sh8000_0000;
		else
			o = s[SUM_W-1:0];
		return o;
	endfunction

	assign ang_in     = s_tdata[19:0];
	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign out_free   = !m_tvalid_q || m_tready;
	assign count_full = &count_q;

	assign phase  = {ang_in[15:0], 16'h0000};
	assign flip_w = phase[31] ^ phase[30];

	assign new_min = (ang_q < min_q) ? ang_q : min_q;
	assign new_max = (ang_q > max_q) ? ang_q : max_q;
	assign span_w  = new_max - new_min;
	assign elapsed = now_q - start_q;
	assign fin_w   = (elapsed >= calib_time);
	assign rej_w   = (span_w > max_span);
	assign zero_w  = (sin_sum_q == '0) && (cos_sum_q == '0);

	assign xf      = flip_q ? -res.x : res.x;
	assign yf      = flip_q ? -res.y : res.y;
	assign z_round = res.z + 34'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.vec   = 1'b0;
		cmd.x0    = GAIN_Q30;
		cmd.y0    = '0;
		cmd.z0    = {{(Z_W-32){phase[31] ^ flip_w}}, phase[31] ^ flip_w, phase[30:0]};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser && running_q && !count_full) begin
						cmd.start = 1'b1;
						state_d   = ST_ROT;
					end else if (s_tuser && running_q) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_ROT: begin
				if (res.done)
					state_d = ST_ACCUM;
			end
			ST_ACCUM: state_d = ST_CHECK;
			ST_CHECK: begin
				if (fin_w && !rej_w && !zero_w) begin
					cmd.start = 1'b1;
					cmd.vec   = 1'b1;
					if (cos_sum_q[SUM_W-1]) begin
						cmd.x0 = -XY_W'(cos_sum_q);
						cmd.y0 = -XY_W'(sin_sum_q);
						cmd.z0 = 34'sh0_8000_0000;
					end else begin
						cmd.x0 = XY_W'(cos_sum_q);
						cmd.y0 = XY_W'(sin_sum_q);
						cmd.z0 = '0;
					end
					state_d = ST_VEC;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_VEC: begin
				if (res.done)
					state_d = ST_VEC_DONE;
			end
			ST_VEC_DONE: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			ready_q    <= 1'b0;
			rejected_q <= 1'b0;
			fin_q      <= 1'b0;
			start_q    <= '0;
			count_q    <= '0;
			sin_sum_q  <= '0;
			cos_sum_q  <= '0;
			min_q      <= ANG_MAX;
			max_q      <= ANG_MIN;
			span_q     <= '0;
			offset_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fin_q <= 1'b0;
						if (!s_tuser) begin
							running_q  <= 1'b1;
							ready_q    <= 1'b0;
							rejected_q <= 1'b0;
							start_q    <= s_tdata[51:20];
							count_q    <= '0;
							sin_sum_q  <= '0;
							cos_sum_q  <= '0;
							min_q      <= ANG_MAX;
							max_q      <= ANG_MIN;
							span_q     <= '0;
							offset_q   <= '0;
						end
					end
				end
				ST_ACCUM: begin
					sin_sum_q <= sat_add(sin_sum_q, to_q15(yf));
					cos_sum_q <= sat_add(cos_sum_q, to_q15(xf));
					count_q   <= count_q + 1'b1;
				end
				ST_CHECK: begin
					min_q <= new_min;
					max_q <= new_max;
					if (fin_w) begin
						running_q <= 1'b0;
						fin_q     <= 1'b1;
						span_q    <= span_w;
						if (rej_w) begin
							ready_q    <= 1'b0;
							rejected_q <= 1'b1;
						end else if (zero_w) begin
							offset_q   <= '0;
							ready_q    <= 1'b1;
							rejected_q <= 1'b0;
						end
					end
				end
				ST_VEC_DONE: begin
					offset_q   <= z_round[31:16];
					ready_q    <= 1'b1;
					rejected_q <= 1'b0;
				end
				default: begin
				end
			endcase

			if (state_q == ST_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ang_q  <= ang_in;
			now_q  <= s_tdata[51:20];
			flip_q <= flip_w;
		end
		if (state_q == ST_OUT && out_free)
			m_tdata_q <= {ang_q[15:0] - offset_q, span_q, offset_q,
				rejected_q, ready_q, running_q, fin_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(ready_q && rejected_q))
		else $error("offset both accepted and rejected");

	assert property (@(posedge clk) disable iff (!arst_n) !(running_q && ready_q))
		else $error("offset ready while calibration still running");

	assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (state_q == ST_ROT || state_q == ST_VEC))
		else $error("CORDIC finished outside a wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && fin_w) |=> !running_q)
		else $error("window end did not stop calibration");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tuser) |=> (running_q && !ready_q && !rejected_q && offset_q == '0))
		else $error("start transaction did not clear calibration state");

endmodule
